// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the checker file pps_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int MaxProcs   = 16;
   localparam int TimeBits   = 12;
   localparam int PrioBits   = 8;
   localparam int ResBits    = 17;
   localparam int ProcIdBits = 4;
   localparam int IdxBits    = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
   localparam int CntBits    = $clog2(MaxProcs + 1);

   localparam logic [ResBits-1:0] ResMax = '1;

   typedef struct packed {
      logic [TimeBits-1:0] arrival_time;
      logic [TimeBits-1:0] burst_time;
      logic [PrioBits-1:0] prio_level;
      logic                last_proc;
   } req_item_type;

   typedef struct packed {
      logic [ProcIdBits-1:0] proc_id;
      logic [ResBits-1:0]    wait_ticks;
      logic [ResBits-1:0]    turnaround_ticks;
      logic                  last_result;
   } rsp_item_type;

   // one process table entry as seen on the read port
   typedef struct packed {
      logic [TimeBits-1:0] arrival;
      logic [TimeBits-1:0] burst;
      logic [PrioBits-1:0] prio;
      logic [TimeBits-1:0] remaining;
   } entry_type;

   // outcome of one scan over the table
   typedef struct packed {
      logic                found;
      logic [IdxBits-1:0]  best_idx;
      logic [TimeBits-1:0] best_arrival;
      logic [TimeBits-1:0] best_burst;
      logic [TimeBits-1:0] best_remaining;
      logic                have_next;
      logic [TimeBits-1:0] next_arrival;
   } pick_type;

endpackage

// ===== sv/pps_store.sv =====
// ----------------------------------------------------------------------------
// pps_store
// Process tables: arrival, burst, priority, remaining and wait, one read port.
// ----------------------------------------------------------------------------
module pps_store import pps_pkg::*; (
   input  logic                clock,
   input  logic                ld_en,
   input  logic [IdxBits-1:0]  ld_idx,
   input  req_item_type        ld_item,
   input  logic                rem_we,
   input  logic [IdxBits-1:0]  rem_idx,
   input  logic [TimeBits-1:0] rem_val,
   input  logic                wait_we,
   input  logic [IdxBits-1:0]  wait_idx,
   input  logic [ResBits-1:0]  wait_val,
   input  logic [IdxBits-1:0]  rd_idx,
   output entry_type           rd_entry,
   output logic [ResBits-1:0]  rd_wait
);

   logic [TimeBits-1:0] arrival_ff   [MaxProcs];
   logic [TimeBits-1:0] burst_ff     [MaxProcs];
   logic [PrioBits-1:0] prio_ff      [MaxProcs];
   logic [TimeBits-1:0] remaining_ff [MaxProcs];
   logic [ResBits-1:0]  wait_ff      [MaxProcs];

   // load writes a whole entry, the scheduler only updates remaining and wait
   always_ff @(posedge clock) begin
      if (ld_en) begin
         arrival_ff[ld_idx]   <= ld_item.arrival_time;
         burst_ff[ld_idx]     <= ld_item.burst_time;
         prio_ff[ld_idx]      <= ld_item.prio_level;
         remaining_ff[ld_idx] <= ld_item.burst_time;
      end else if (rem_we) begin
         remaining_ff[rem_idx] <= rem_val;
      end
      if (wait_we) begin
         wait_ff[wait_idx] <= wait_val;
      end
   end

   // single read port shared by the scan and the result stage
   always_comb begin
      rd_entry.arrival   = arrival_ff[rd_idx];
      rd_entry.burst     = burst_ff[rd_idx];
      rd_entry.prio      = prio_ff[rd_idx];
      rd_entry.remaining = remaining_ff[rd_idx];
      rd_wait            = wait_ff[rd_idx];
   end

endmodule

// ===== sv/pps_pick.sv =====
// ----------------------------------------------------------------------------
// pps_pick
// Compare unit: walks the table one entry a cycle while step is high, keeping the best ready
// process and the earliest pending arrival.
// ----------------------------------------------------------------------------
module pps_pick import pps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               first,
   input  logic [IdxBits-1:0] idx,
   input  entry_type          entry,
   input  logic [ResBits-1:0] now,
   output pick_type           pick
);

   logic                found_ff, found_in;
   logic                have_next_ff, have_next_in;
   logic [IdxBits-1:0]  best_idx_ff;
   logic [PrioBits-1:0] best_prio_ff;
   logic [TimeBits-1:0] best_arrival_ff, best_burst_ff, best_remaining_ff;
   logic [TimeBits-1:0] next_arrival_ff;
   logic                live, is_ready, take_best, take_next;

   // strict compare keeps the lowest index on equal priority
   always_comb begin
      live      = (entry.remaining != '0);
      is_ready  = (ResBits'(entry.arrival) <= now);
      take_best = live && is_ready && (first || !found_ff || (entry.prio < best_prio_ff));
      take_next = live && !is_ready &&
                  (first || !have_next_ff || (entry.arrival < next_arrival_ff));
      found_in     = take_best || (!first && found_ff);
      have_next_in = take_next || (!first && have_next_ff);
   end

   // flags
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         have_next_ff <= 1'b0;
      end else if (step) begin
         found_ff     <= found_in;
         have_next_ff <= have_next_in;
      end
   end

   // candidate payload
   always_ff @(posedge clock) begin
      if (step && take_best) begin
         best_idx_ff       <= idx;
         best_prio_ff      <= entry.prio;
         best_arrival_ff   <= entry.arrival;
         best_burst_ff     <= entry.burst;
         best_remaining_ff <= entry.remaining;
      end
      if (step && take_next) begin
         next_arrival_ff <= entry.arrival;
      end
   end

   always_comb begin
      pick.found          = found_ff;
      pick.best_idx       = best_idx_ff;
      pick.best_arrival   = best_arrival_ff;
      pick.best_burst     = best_burst_ff;
      pick.best_remaining = best_remaining_ff;
      pick.have_next      = have_next_ff;
      pick.next_arrival   = next_arrival_ff;
   end

endmodule

// ===== sv/preemptive_priority_scheduler_sim.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_sim
// Loads a set of processes, then simulates preemptive priority scheduling
// and returns wait and turnaround per process in load order.
// ----------------------------------------------------------------------------
// Processes load at one item per cycle, up to 16; items beyond that are
// dropped, and the item marked last_proc starts the run. The run proceeds
// in scheduling events, each a scan of the n loaded entries through one
// shared compare unit followed by an update step, plus a finish step when
// a process finishes. An event ends at a finish, an arrival or an idle jump.
// Results then leave at one item per cycle while the sink is ready; the
// block takes the next set's items as soon as the last result is registered.
module preemptive_priority_scheduler_sim import pps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   typedef enum logic [4:0] {
      S_LOAD  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_APPLY = 5'b00100,
      S_FIN   = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [CntBits-1:0] count_ff, count_in;
   logic [CntBits-1:0] live_ff, live_in;
   logic [CntBits-1:0] idx_ff, idx_in;
   logic [ResBits-1:0] now_ff, now_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic                accept, has_room, load_out, at_end;
   logic                rem_we, wait_we;
   logic [TimeBits-1:0] rem_val, chunk;
   logic [ResBits-1:0]  gap, wait_val;
   logic [ResBits:0]    wait_wide, ta_wide;
   logic [ResBits-1:0]  out_wait;
   logic [CntBits-1:0]  live_load;
   entry_type           rd_entry;
   logic [ResBits-1:0]  rd_wait;
   pick_type            pick;

   assign req_ready = (state_ff == S_LOAD);
   assign accept    = req_valid && req_ready;
   assign has_room  = (count_ff < CntBits'(MaxProcs));
   assign at_end    = (idx_ff == count_ff - 1'b1);
   assign load_out  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   pps_store u_store (
      .clock    (clock),
      .ld_en    (accept && has_room),
      .ld_idx   (count_ff[IdxBits-1:0]),
      .ld_item  (req_item),
      .rem_we   (rem_we),
      .rem_idx  (pick.best_idx),
      .rem_val  (rem_val),
      .wait_we  (wait_we),
      .wait_idx (pick.best_idx),
      .wait_val (wait_val),
      .rd_idx   (idx_ff[IdxBits-1:0]),
      .rd_entry (rd_entry),
      .rd_wait  (rd_wait)
   );

   pps_pick u_pick (
      .clock (clock),
      .reset (reset),
      .step  (state_ff == S_SCAN),
      .first (idx_ff == '0),
      .idx   (idx_ff[IdxBits-1:0]),
      .entry (rd_entry),
      .now   (now_ff),
      .pick  (pick)
   );

   // service slice: run the best process up to its finish or the next arrival
   always_comb begin
      gap     = ResBits'(pick.next_arrival) - now_ff;
      chunk   = (pick.have_next && (gap < ResBits'(pick.best_remaining)))
                ? gap[TimeBits-1:0] : pick.best_remaining;
      rem_val = pick.best_remaining - chunk;
      rem_we  = (state_ff == S_APPLY) && pick.found;
   end

   // wait on completion: finish time minus burst minus arrival, saturated
   always_comb begin
      wait_wide = {1'b0, now_ff} - (ResBits + 1)'(pick.best_burst)
                  - (ResBits + 1)'(pick.best_arrival);
      wait_val  = wait_wide[ResBits] ? ResMax : wait_wide[ResBits-1:0];
      wait_we   = (state_ff == S_FIN);
   end

   // result for the entry under the counter
   always_comb begin
      out_wait = (rd_entry.burst == '0) ? '0 : rd_wait;
      ta_wide  = {1'b0, out_wait} + (ResBits + 1)'(rd_entry.burst);
      rsp_item_in.proc_id          = ProcIdBits'(idx_ff);
      rsp_item_in.wait_ticks       = out_wait;
      rsp_item_in.turnaround_ticks = (rd_entry.burst == '0) ? '0
                                     : (ta_wide[ResBits] ? ResMax : ta_wide[ResBits-1:0]);
      rsp_item_in.last_result      = at_end;
   end

   assign live_load = live_ff + CntBits'(has_room && (req_item.burst_time != '0));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      live_in      = live_ff;
      idx_in       = idx_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               count_in = count_ff + CntBits'(has_room);
               live_in  = live_load;
               if (req_item.last_proc) begin
                  idx_in   = '0;
                  now_in   = '0;
                  state_in = (live_load == '0) ? S_OUT : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (at_end) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            idx_in = '0;
            if (!pick.found) begin
               // nothing ready: jump to the next arrival
               now_in   = ResBits'(pick.next_arrival);
               state_in = S_SCAN;
            end else begin
               now_in   = now_ff + ResBits'(chunk);
               state_in = (rem_val == '0) ? S_FIN : S_SCAN;
            end
         end
         S_FIN: begin
            idx_in   = '0;
            live_in  = live_ff - 1'b1;
            state_in = (live_ff == CntBits'(1)) ? S_OUT : S_SCAN;
         end
         S_OUT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               idx_in       = idx_ff + 1'b1;
               if (at_end) begin
                  count_in = '0;
                  live_in  = '0;
                  now_in   = '0;
                  state_in = S_LOAD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         live_ff      <= '0;
         idx_ff       <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         live_ff      <= live_in;
         idx_ff       <= idx_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output item register
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== sv/pps_checker.sv =====
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pps_checker import pps_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_item_type req_item,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_item
);

   // a stalled result item holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item))

   // the last item of a set starts the run, so loading stops
   `ASSERT_NEXT(a_last_stops_load, clock, reset, req_valid && req_ready && req_item.last_proc, !req_ready)

   // loading goes on until the last item
   `ASSERT_NEXT(a_load_continues, clock, reset, req_valid && req_ready && !req_item.last_proc, req_ready)

   // turnaround never falls below wait
   `ASSERT_SAME(a_ta_ge_wait, clock, reset, rsp_valid, rsp_item.turnaround_ticks >= rsp_item.wait_ticks)

endmodule

bind preemptive_priority_scheduler_sim pps_checker u_pps_checker (.*);
